### src/clcd_pkg.sv
// Shared types and constants for the character LCD nibble command sequencer.
// No dependencies; every other file in src imports this package.
package clcd_pkg;

  localparam int ROWS = 4;
  localparam int COLS = 20;

  // request codes
  localparam logic [2:0] ACT_INIT      = 3'd0;
  localparam logic [2:0] ACT_WRITE     = 3'd1;
  localparam logic [2:0] ACT_CURSOR    = 3'd2;
  localparam logic [2:0] ACT_CLEAR     = 3'd3;
  localparam logic [2:0] ACT_DISP_ON   = 3'd4;
  localparam logic [2:0] ACT_DISP_OFF  = 3'd5;
  localparam logic [2:0] ACT_GLYPH_ROW = 3'd6;

  // register-select codes
  localparam logic RS_CMD  = 1'b0;
  localparam logic RS_DATA = 1'b1;

  localparam logic [7:0]  CMD_CLEAR     = 8'h01;
  localparam logic [7:0]  CMD_DISP_ON   = 8'h0C;
  localparam logic [7:0]  CMD_DISP_OFF  = 8'h08;
  localparam logic [7:0]  CMD_DDRAM     = 8'h80;
  localparam logic [7:0]  CMD_CGRAM     = 8'h40;

  localparam logic [12:0] BASE_SETTLE   = 13'd100;
  localparam logic [12:0] CLEAR_EXTRA   = 13'd2000;
  localparam logic [15:0] INIT_LEAD     = 16'd50000;

  localparam logic [4:0]  CNT_INIT      = 5'd16;
  localparam logic [4:0]  CNT_BYTE      = 5'd2;
  localparam logic [4:0]  CNT_TWO_BYTES = 5'd4;

  localparam logic [6:0] ROW_BASE [4] = '{7'h00, 7'h40, 7'h14, 7'h54};

  localparam logic [7:0] INIT_BYTES [8] = '{
    8'h03, 8'h03, 8'h03, 8'h02, 8'h28, 8'h08, 8'h01, 8'h06
  };

  localparam logic [12:0] INIT_EXTRA [8] = '{
    13'd5000, 13'd5000, 13'd500, 13'd0, 13'd0, 13'd0, 13'd2000, 13'd0
  };

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] char_code;
    logic [7:0] cursor_row;
    logic [7:0] cursor_col;
    logic [7:0] glyph_slot;
    logic [2:0] glyph_row;
    logic [7:0] glyph_bits;
  } clcd_req_t;

  typedef struct packed {
    logic        reg_select;
    logic [3:0]  nibble;
    logic [15:0] lead_wait_us;
    logic [12:0] settle_us;
    logic        last_strobe;
  } clcd_strobe_t;

endpackage

### src/clcd_strobe_gen.sv
// Combinational strobe generator: held request plus strobe index to one strobe.
// Depends on clcd_pkg.
module clcd_strobe_gen
  import clcd_pkg::*;
(
  input  clcd_req_t    req,
  input  logic [3:0]   idx,
  output clcd_strobe_t strobe,
  output logic [4:0]   cnt
);

  logic [2:0]  byte_idx;
  logic        lo_half;
  logic        rs;
  logic [7:0]  byte_val;
  logic [12:0] extra;
  logic [2:0]  row_sat;
  logic [4:0]  col_sat;
  logic [6:0]  ddram_addr;
  logic [1:0]  row_sel;

  assign byte_idx = idx[3:1];
  assign lo_half  = idx[0];

  always_comb begin
    if (req.cursor_row == 8'd0) begin
      row_sat = 3'd1;
    end else if (req.cursor_row > 8'(ROWS)) begin
      row_sat = 3'(ROWS);
    end else begin
      row_sat = req.cursor_row[2:0];
    end
    if (req.cursor_col == 8'd0) begin
      col_sat = 5'd1;
    end else if (req.cursor_col > 8'(COLS)) begin
      col_sat = 5'(COLS);
    end else begin
      col_sat = req.cursor_col[4:0];
    end
  end

  assign row_sel    = 2'(row_sat - 3'd1);
  assign ddram_addr = ROW_BASE[row_sel] + {2'b00, col_sat} - 7'd1;

  always_comb begin
    rs       = RS_CMD;
    byte_val = 8'h00;
    extra    = 13'd0;
    cnt      = CNT_BYTE;
    case (req.action)
      ACT_INIT: begin
        byte_val = INIT_BYTES[byte_idx];
        extra    = INIT_EXTRA[byte_idx];
        cnt      = CNT_INIT;
      end
      ACT_WRITE: begin
        rs       = RS_DATA;
        byte_val = req.char_code;
      end
      ACT_CURSOR: begin
        byte_val = CMD_DDRAM | {1'b0, ddram_addr};
      end
      ACT_CLEAR: begin
        byte_val = CMD_CLEAR;
        extra    = CLEAR_EXTRA;
      end
      ACT_DISP_ON: begin
        byte_val = CMD_DISP_ON;
      end
      ACT_DISP_OFF: begin
        byte_val = CMD_DISP_OFF;
      end
      ACT_GLYPH_ROW: begin
        // row 0 sets the CGRAM address first, later rows ride the auto-increment
        if (req.glyph_row == 3'd0) begin
          cnt = CNT_TWO_BYTES;
        end
        if (req.glyph_row == 3'd0 && byte_idx == 3'd0) begin
          byte_val = CMD_CGRAM | {2'b00, req.glyph_slot[2:0], 3'b000};
        end else begin
          rs       = RS_DATA;
          byte_val = req.glyph_bits;
        end
      end
      default: begin
        cnt = 5'd0;
      end
    endcase
  end

  always_comb begin
    strobe.reg_select   = rs;
    strobe.nibble       = lo_half ? byte_val[3:0] : byte_val[7:4];
    strobe.lead_wait_us = (req.action == ACT_INIT && idx == 4'd0) ? INIT_LEAD : 16'd0;
    strobe.settle_us    = lo_half ? (BASE_SETTLE + extra) : BASE_SETTLE;
    strobe.last_strobe  = ({1'b0, idx} == cnt - 5'd1);
  end

endmodule

### src/clcd_out_stage.sv
// Output register stage: holds one strobe until the sink takes it.
// Depends on clcd_pkg.
module clcd_out_stage
  import clcd_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         load,
  input  clcd_strobe_t load_data,
  output logic         can_load,
  output logic         out_valid,
  input  logic         out_ready,
  output clcd_strobe_t strobe
);

  // free when empty or when the held beat leaves this cycle
  assign can_load = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (can_load) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (can_load && load) begin
      strobe <= load_data;
    end
  end

endmodule

### src/char_lcd_nibble_command_sequencer_core.sv
// Top level of the character LCD 4-bit write sequencer.
// Depends on clcd_pkg, clcd_strobe_gen and clcd_out_stage.
//
// Each accepted request is expanded into the enable strobes a character LCD
// needs on a 4-bit bus: every byte as high nibble then low nibble, each
// strobe tagged with register select, lead wait and settle time in
// microseconds, the final one flagged by last_strobe. One strobe leaves per
// cycle while the output register can take it (a stall on out_ready holds it):
// 2 strobes for most requests, 4 for a glyph row 0, 16 for init; an unknown
// request code emits nothing. The strobe counter over the held request sets
// this pace, and the next request is taken in the cycle its predecessor's
// last strobe enters the output register.
module char_lcd_nibble_command_sequencer_core
  import clcd_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         req_valid,
  output logic         req_ready,
  input  clcd_req_t    req,
  output logic         out_valid,
  input  logic         out_ready,
  output clcd_strobe_t strobe
);

  clcd_req_t    held;
  logic         busy;
  logic [3:0]   idx;
  logic         busy_next;
  logic [3:0]   idx_next;
  clcd_strobe_t gen_strobe;
  logic [4:0]   gen_cnt;
  logic         can_load;
  logic         emit;
  logic         done;
  logic         accept;

  clcd_strobe_gen u_gen (
    .req    (held),
    .idx    (idx),
    .strobe (gen_strobe),
    .cnt    (gen_cnt)
  );

  clcd_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (emit),
    .load_data (gen_strobe),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .strobe    (strobe)
  );

  assign emit      = busy && gen_cnt != 5'd0 && can_load;
  assign done      = busy && (gen_cnt == 5'd0 || (emit && gen_strobe.last_strobe));
  assign req_ready = !busy || done;
  assign accept    = req_valid && req_ready;

  always_comb begin
    busy_next = busy;
    idx_next  = idx;
    if (accept) begin
      busy_next = 1'b1;
      idx_next  = 4'd0;
    end else if (done) begin
      busy_next = 1'b0;
      idx_next  = 4'd0;
    end else if (emit) begin
      idx_next = idx + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= 4'd0;
    end else begin
      busy <= busy_next;
      idx  <= idx_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held <= req;
    end
  end

  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    busy && gen_cnt != 5'd0 |-> {1'b0, idx} < gen_cnt)
    else $error("strobe index ran past the request's strobe count");

  a_last_frees_input: assert property (@(posedge clk) disable iff (rst)
    emit && gen_strobe.last_strobe |-> req_ready)
    else $error("last strobe emitted but request side not ready");

  a_idle_after_done: assert property (@(posedge clk) disable iff (rst)
    done && !accept |=> !busy)
    else $error("sequencer stayed busy after finishing a request");

  a_lead_first_only: assert property (@(posedge clk) disable iff (rst)
    emit && gen_strobe.lead_wait_us != 16'd0 |-> idx == 4'd0 && held.action == ACT_INIT)
    else $error("lead wait on a strobe other than the first init strobe");

  a_new_req_starts_at_zero: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy && idx == 4'd0)
    else $error("accepted request did not start at strobe zero");

endmodule
